// File: hw/rtl/length_prefixed_topic_frame_parser_assert.svh
// Assertion macros for the length-prefixed topic frame parser.
// Included by the top level; no other dependencies.
`ifndef LENGTH_PREFIXED_TOPIC_FRAME_PARSER_ASSERT_SVH
`define LENGTH_PREFIXED_TOPIC_FRAME_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
// Check an implication on every clock edge outside reset
`define LPTF_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that a condition never holds outside reset
`define LPTF_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define LPTF_ASSERT(label, clk, rstn, prop, msg)
`define LPTF_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

// File: hw/rtl/lptf_pkg.sv
// Shared types and constants for the length-prefixed topic frame parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lptf_pkg;

    // Byte counter and length widths
    localparam int COUNT_W    = 32;
    localparam int DATA_W     = 8;
    localparam int TOPIC_W    = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Frame layout positions
    localparam logic [COUNT_W-1:0] PREFIX_LEN  = 32'd4;  // body length bytes
    localparam logic [COUNT_W-1:0] PRIO_IDX    = 32'd4;  // priority byte
    localparam logic [COUNT_W-1:0] TOPIC_START = 32'd7;  // first topic byte
    localparam logic [COUNT_W-1:0] HEADER_LEN  = 32'd3;  // priority + topic length

    // Register map (word index)
    localparam logic [APB_ADDR_W-3:0] REG_MAX_PRIORITY   = 1'b0;
    localparam logic [DATA_W-1:0]     MAX_PRIORITY_RESET = 8'd3;

    typedef enum logic [2:0] {
        KIND_LEN_PREFIX = 3'd0,
        KIND_PRIORITY   = 3'd1,
        KIND_TOPIC_LEN  = 3'd2,
        KIND_TOPIC      = 3'd3,
        KIND_PAYLOAD    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_SHORT_PREFIX = 3'd1,
        STATUS_LEN_MISMATCH = 3'd2,
        STATUS_SHORT_BODY   = 3'd3,
        STATUS_BAD_PRIORITY = 3'd4,
        STATUS_TOPIC_OVERRUN = 3'd5,
        STATUS_EMPTY_TOPIC  = 3'd6
    } status_t;

    // One parsed word with the frame header as seen after it
    typedef struct packed {
        logic [DATA_W-1:0]  data;
        kind_t              kind;
        logic               last;
        logic [COUNT_W-1:0] total;
        logic [COUNT_W-1:0] body_len;
        logic [DATA_W-1:0]  prio;
        logic [TOPIC_W-1:0] topic_size;
    } frame_snap_t;

endpackage

// File: hw/rtl/length_prefixed_topic_frame_parser.sv
// Length-prefixed topic frame parser. Takes one frame word (byte) per cycle on the s_ channel
// when s_ready is high, s_frame_end on the final byte, and returns one m_ word per byte: the byte,
// its class, and on the last byte the frame status, priority and declared topic length. Sustained
// rate is one byte per clock while m_ready holds high. The input stage register (counter, header
// capture, classification) feeds the result register (status checks). The APB port holds one
// register, max_priority, at byte address 0 (reset value 3); write it only while idle.
// Depends on lptf_pkg, lptf_apb, lptf_parse, lptf_check and the assertion header.
`timescale 1ns / 1ps
`include "length_prefixed_topic_frame_parser_assert.svh"

module length_prefixed_topic_frame_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lptf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lptf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lptf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [lptf_pkg::DATA_W-1:0]       s_data_byte,
    input  logic                              s_frame_end,
    // result words
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lptf_pkg::DATA_W-1:0]       m_byte_out,
    output logic [2:0]                        m_byte_kind,
    output logic                              m_last,
    output logic [2:0]                        m_status,
    output logic [lptf_pkg::DATA_W-1:0]       m_priority_res,
    output logic [lptf_pkg::TOPIC_W-1:0]      m_topic_length
);
    import lptf_pkg::*;

    logic              st_valid;
    logic              st_ready;
    frame_snap_t       st_snap;
    logic [DATA_W-1:0] max_priority;

    lptf_apb u_apb (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .max_priority (max_priority)
    );

    lptf_parse u_parse (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data_byte (s_data_byte),
        .s_frame_end (s_frame_end),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .st_valid    (st_valid),
        .st_snap     (st_snap),
        .st_ready    (st_ready)
    );

    lptf_check u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .st_valid       (st_valid),
        .st_snap        (st_snap),
        .st_ready       (st_ready),
        .max_priority   (max_priority),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_out     (m_byte_out),
        .m_byte_kind    (m_byte_kind),
        .m_last         (m_last),
        .m_status       (m_status),
        .m_priority_res (m_priority_res),
        .m_topic_length (m_topic_length)
    );

    // Status fields stay zero on words that do not end a frame
    `LPTF_ASSERT(a_quiet_mid_frame, aclk, aresetn, (m_valid && !m_last) |-> (m_status == STATUS_OK && m_priority_res == '0 && m_topic_length == '0), "status fields set on a mid-frame word")
    // A clean frame has a non-empty topic and an allowed priority
    `LPTF_ASSERT(a_ok_consistent, aclk, aresetn, (m_valid && m_last && m_status == STATUS_OK) |-> (m_topic_length != '0 && m_priority_res <= max_priority), "ok status on an invalid header")
    // Prefix bytes come only from the first four positions
    `LPTF_ASSERT_NEVER(a_prefix_pos, aclk, aresetn, st_valid && st_snap.kind == KIND_LEN_PREFIX && st_snap.total > PREFIX_LEN, "length prefix class past the prefix")
    // A word held in the input stage moves on once the result register frees
    `LPTF_ASSERT(a_stage_drains, aclk, aresetn, (st_valid && st_ready && !s_valid) |=> !st_valid, "input stage failed to drain")

endmodule

// File: hw/rtl/lptf_apb.sv
// APB configuration register file: holds max_priority.
// Depends on lptf_pkg.
`timescale 1ns / 1ps

module lptf_apb (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lptf_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lptf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lptf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [lptf_pkg::DATA_W-1:0]       max_priority
);
    import lptf_pkg::*;

    logic [DATA_W-1:0] max_prio_reg;
    logic [DATA_W-1:0] max_prio_next;
    logic              hit;

    assign hit    = (paddr[APB_ADDR_W-1:2] == REG_MAX_PRIORITY);
    assign pready = 1'b1;

    // Write on the access phase
    always_comb begin
        max_prio_next = max_prio_reg;
        if (psel && penable && pwrite && hit) begin
            max_prio_next = pwdata[DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_prio_reg <= MAX_PRIORITY_RESET;
        end else begin
            max_prio_reg <= max_prio_next;
        end
    end

    // Read back, zero outside the map
    assign prdata       = hit ? {{(APB_DATA_W-DATA_W){1'b0}}, max_prio_reg} : '0;
    assign max_priority = max_prio_reg;

endmodule

// File: hw/rtl/lptf_parse.sv
// Input stage: byte counter, header capture, byte classification.
// Depends on lptf_pkg; feeds lptf_check through a frame_snap_t register.
`timescale 1ns / 1ps

module lptf_parse (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [lptf_pkg::DATA_W-1:0]  s_data_byte,
    input  logic                         s_frame_end,
    input  logic                         s_valid,
    output logic                         s_ready,
    output logic                         st_valid,
    output lptf_pkg::frame_snap_t        st_snap,
    input  logic                         st_ready
);
    import lptf_pkg::*;

    logic [COUNT_W-1:0] count_reg,  count_next;
    logic [COUNT_W-1:0] body_reg,   body_next;
    logic [DATA_W-1:0]  prio_reg,   prio_next;
    logic [TOPIC_W-1:0] topic_reg,  topic_next;
    logic               valid_reg,  valid_next;
    frame_snap_t        snap_reg,   snap_next;

    logic [COUNT_W-1:0] body_upd;
    logic [DATA_W-1:0]  prio_upd;
    logic [TOPIC_W-1:0] topic_upd;
    logic [COUNT_W-1:0] total;
    logic [COUNT_W-1:0] topic_off;
    kind_t              kind;
    logic               fire;

    assign s_ready = !valid_reg || st_ready;
    assign fire    = s_valid && s_ready;

    // Fold the current word into the header fields
    always_comb begin
        body_upd  = body_reg;
        prio_upd  = prio_reg;
        topic_upd = topic_reg;
        if (count_reg < PREFIX_LEN) begin
            body_upd = {body_reg[COUNT_W-DATA_W-1:0], s_data_byte};
        end else if (count_reg == PRIO_IDX) begin
            prio_upd = s_data_byte;
        end else if (count_reg < TOPIC_START) begin
            topic_upd = {topic_reg[TOPIC_W-DATA_W-1:0], s_data_byte};
        end
    end

    // Classify by position; saturate the count
    assign topic_off = count_reg - TOPIC_START;
    assign total     = (&count_reg) ? count_reg : count_reg + 1'b1;

    always_comb begin
        if (count_reg < PREFIX_LEN) begin
            kind = KIND_LEN_PREFIX;
        end else if (count_reg == PRIO_IDX) begin
            kind = KIND_PRIORITY;
        end else if (count_reg < TOPIC_START) begin
            kind = KIND_TOPIC_LEN;
        end else if (topic_off < {{(COUNT_W-TOPIC_W){1'b0}}, topic_upd}) begin
            kind = KIND_TOPIC;
        end else begin
            kind = KIND_PAYLOAD;
        end
    end

    // Advance state on accept; clear after the last word
    always_comb begin
        count_next = count_reg;
        body_next  = body_reg;
        prio_next  = prio_reg;
        topic_next = topic_reg;
        snap_next  = snap_reg;
        valid_next = valid_reg;
        if (st_ready) begin
            valid_next = 1'b0;
        end
        if (fire) begin
            valid_next           = 1'b1;
            snap_next.data       = s_data_byte;
            snap_next.kind       = kind;
            snap_next.last       = s_frame_end;
            snap_next.total      = total;
            snap_next.body_len   = body_upd;
            snap_next.prio       = prio_upd;
            snap_next.topic_size = topic_upd;
            if (s_frame_end) begin
                count_next = '0;
                body_next  = '0;
                prio_next  = '0;
                topic_next = '0;
            end else begin
                count_next = total;
                body_next  = body_upd;
                prio_next  = prio_upd;
                topic_next = topic_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            body_reg  <= '0;
            prio_reg  <= '0;
            topic_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            body_reg  <= body_next;
            prio_reg  <= prio_next;
            topic_reg <= topic_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
    end

    assign st_valid = valid_reg;
    assign st_snap  = snap_reg;

endmodule

// File: hw/rtl/lptf_check.sv
// Result stage: frame status checks and the output register.
// Depends on lptf_pkg; takes frame_snap_t words from lptf_parse.
`timescale 1ns / 1ps

module lptf_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          st_valid,
    input  lptf_pkg::frame_snap_t         st_snap,
    output logic                          st_ready,
    input  logic [lptf_pkg::DATA_W-1:0]   max_priority,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lptf_pkg::DATA_W-1:0]   m_byte_out,
    output logic [2:0]                    m_byte_kind,
    output logic                          m_last,
    output logic [2:0]                    m_status,
    output logic [lptf_pkg::DATA_W-1:0]   m_priority_res,
    output logic [lptf_pkg::TOPIC_W-1:0]  m_topic_length
);
    import lptf_pkg::*;

    localparam logic [COUNT_W:0] HEADER_LEN_X = {1'b0, HEADER_LEN};

    logic               valid_reg, valid_next;
    logic [DATA_W-1:0]  data_reg,  data_next;
    kind_t              kind_reg,  kind_next;
    logic               last_reg,  last_next;
    status_t            stat_reg,  stat_next;
    logic [DATA_W-1:0]  prio_reg,  prio_next;
    logic [TOPIC_W-1:0] topic_reg, topic_next;

    status_t            status;
    logic [COUNT_W:0]   need_len;

    assign st_ready = !valid_reg || m_ready;
    assign need_len = HEADER_LEN_X + {{(COUNT_W-TOPIC_W+1){1'b0}}, st_snap.topic_size};

    // First failing check gives the status
    always_comb begin
        if (st_snap.total < PREFIX_LEN) begin
            status = STATUS_SHORT_PREFIX;
        end else if (st_snap.body_len != st_snap.total - PREFIX_LEN) begin
            status = STATUS_LEN_MISMATCH;
        end else if (st_snap.body_len < HEADER_LEN) begin
            status = STATUS_SHORT_BODY;
        end else if (st_snap.prio > max_priority) begin
            status = STATUS_BAD_PRIORITY;
        end else if ({1'b0, st_snap.body_len} < need_len) begin
            status = STATUS_TOPIC_OVERRUN;
        end else if (st_snap.topic_size == '0) begin
            status = STATUS_EMPTY_TOPIC;
        end else begin
            status = STATUS_OK;
        end
    end

    // Load the result register; hold while stalled
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        stat_next  = stat_reg;
        prio_next  = prio_reg;
        topic_next = topic_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (st_valid && st_ready) begin
            valid_next = 1'b1;
            data_next  = st_snap.data;
            kind_next  = st_snap.kind;
            last_next  = st_snap.last;
            stat_next  = st_snap.last ? status : STATUS_OK;
            prio_next  = st_snap.last ? st_snap.prio : '0;
            topic_next = st_snap.last ? st_snap.topic_size : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        kind_reg  <= kind_next;
        last_reg  <= last_next;
        stat_reg  <= stat_next;
        prio_reg  <= prio_next;
        topic_reg <= topic_next;
    end

    assign m_valid        = valid_reg;
    assign m_byte_out     = data_reg;
    assign m_byte_kind    = kind_reg;
    assign m_last         = last_reg;
    assign m_status       = stat_reg;
    assign m_priority_res = prio_reg;
    assign m_topic_length = topic_reg;

endmodule

// File: bench/length_prefixed_topic_frame_parser_test.sv
// Self-checking bench for length_prefixed_topic_frame_parser: sends whole frames word by word,
// predicts each result word and compares it field by field. Depends on lptf_pkg and the RTL.
`timescale 1ns / 1ps
module length_prefixed_topic_frame_parser_test;
    import lptf_pkg::*;

    localparam int CLK_HALF_NS   = 4;
    localparam int IDLE_PCT      = 27;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_PRINTS    = 40;
    localparam int TIMEOUT_NS    = 2_000_000;

    typedef logic [DATA_W-1:0] octet_q_t [$];

    // One result word as the parser should produce it
    typedef struct {
        logic [DATA_W-1:0]  data;
        kind_t              kind;
        logic               last;
        status_t            status;
        logic [DATA_W-1:0]  prio;
        logic [TOPIC_W-1:0] topic_size;
    } parsed_word_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic [DATA_W-1:0]     s_data_byte = '0;
    logic                  s_frame_end = 1'b0;

    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [DATA_W-1:0]     m_byte_out;
    logic [2:0]            m_byte_kind;
    logic                  m_last;
    logic [2:0]            m_status;
    logic [DATA_W-1:0]     m_priority_res;
    logic [TOPIC_W-1:0]    m_topic_length;

    // Parser state mirrored by the predictor
    logic [31:0]           frame_pos   = '0;
    logic [31:0]           body_len    = '0;
    logic [DATA_W-1:0]     prio_seen   = '0;
    logic [TOPIC_W-1:0]    topic_seen  = '0;
    logic [DATA_W-1:0]     prio_limit  = MAX_PRIORITY_RESET;

    parsed_word_t          parsed_words [$];

    int                    errors        = 0;
    int                    words_sent    = 0;
    int                    words_checked = 0;
    int                    frames_sent   = 0;
    int                    status_hits [7];
    int                    hold_left     = 0;
    bit                    steady        = 1'b0;
    logic [DATA_W-1:0]     odd_limit;

    length_prefixed_topic_frame_parser u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_byte_out     (m_byte_out),
        .m_byte_kind    (m_byte_kind),
        .m_last         (m_last),
        .m_status       (m_status),
        .m_priority_res (m_priority_res),
        .m_topic_length (m_topic_length)
    );

    always #(CLK_HALF_NS) aclk = ~aclk;

    // Report one mismatch and count it
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t: mismatch on word %0d, %s: got 0x%0h, expected 0x%0h",
                     $realtime, words_checked, what, got, want);
    endtask

    // Decide the status of a frame that ends with the given byte total
    function automatic status_t frame_verdict(input logic [31:0] total);
        if (total < PREFIX_LEN)
            return STATUS_SHORT_PREFIX;
        if (body_len != total - PREFIX_LEN)
            return STATUS_LEN_MISMATCH;
        if (body_len < HEADER_LEN)
            return STATUS_SHORT_BODY;
        if (prio_seen > prio_limit)
            return STATUS_BAD_PRIORITY;
        if (body_len < HEADER_LEN + {16'd0, topic_seen})
            return STATUS_TOPIC_OVERRUN;
        if (topic_seen == '0)
            return STATUS_EMPTY_TOPIC;
        return STATUS_OK;
    endfunction

    // Advance the mirrored parser by one accepted word and queue its result
    function automatic void parse_byte(input logic [DATA_W-1:0] value, input logic is_end);
        parsed_word_t w;
        logic [31:0]  idx;
        logic [31:0]  total;
        idx = frame_pos;
        if (idx < PREFIX_LEN)
            body_len = {body_len[23:0], value};
        else if (idx == PRIO_IDX)
            prio_seen = value;
        else if (idx < TOPIC_START)
            topic_seen = {topic_seen[7:0], value};

        if (idx < PREFIX_LEN)
            w.kind = KIND_LEN_PREFIX;
        else if (idx == PRIO_IDX)
            w.kind = KIND_PRIORITY;
        else if (idx < TOPIC_START)
            w.kind = KIND_TOPIC_LEN;
        else if (idx - TOPIC_START < {16'd0, topic_seen})
            w.kind = KIND_TOPIC;
        else
            w.kind = KIND_PAYLOAD;

        // hold the count at all ones once it gets there
        total  = (idx == '1) ? idx : idx + 32'd1;
        w.data = value;
        w.last = is_end;
        if (is_end) begin
            w.status     = frame_verdict(total);
            w.prio       = prio_seen;
            w.topic_size = topic_seen;
            status_hits[w.status]++;
            frame_pos  = '0;
            body_len   = '0;
            prio_seen  = '0;
            topic_seen = '0;
        end else begin
            w.status     = STATUS_OK;
            w.prio       = '0;
            w.topic_size = '0;
            frame_pos    = total;
        end
        parsed_words.push_back(w);
    endfunction

    // Receiver: long hold-off when asked, else random stalls unless steady
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin : check_words
        parsed_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (parsed_words.size() == 0) begin
                flag_mismatch("word with nothing pending", 32'(m_byte_out), 32'd0);
            end else begin
                w = parsed_words.pop_front();
                if (m_byte_out !== w.data)
                    flag_mismatch("byte_out", 32'(m_byte_out), 32'(w.data));
                if (m_byte_kind !== w.kind)
                    flag_mismatch("byte_kind", 32'(m_byte_kind), 32'(w.kind));
                if (m_last !== w.last)
                    flag_mismatch("last", 32'(m_last), 32'(w.last));
                if (m_status !== w.status)
                    flag_mismatch("status", 32'(m_status), 32'(w.status));
                if (m_priority_res !== w.prio)
                    flag_mismatch("priority_res", 32'(m_priority_res), 32'(w.prio));
                if (m_topic_length !== w.topic_size)
                    flag_mismatch("topic_length", 32'(m_topic_length), 32'(w.topic_size));
            end
            words_checked++;
        end
    end

    // Offer one word and wait for it to be taken; starts and ends just after a falling edge
    task automatic send_byte(input logic [DATA_W-1:0] value, input logic is_end);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid     <= 1'b1;
        s_data_byte <= value;
        s_frame_end <= is_end;
        do @(posedge aclk); while (!s_ready);
        parse_byte(value, is_end);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame(input octet_q_t f);
        for (int i = 0; i < f.size(); i++)
            send_byte(f[i], i == f.size() - 1);
        frames_sent++;
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (parsed_words.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write max_priority over APB, then read it back
    task automatic write_max_priority(input logic [DATA_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_PRIORITY, 2'b00};
        pwdata  <= {{(APB_DATA_W-DATA_W){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        prio_limit = value;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback[DATA_W-1:0] !== value)
            flag_mismatch("max_priority readback", readback, 32'(value));
    endtask

    // Build a frame whose length prefix matches its body
    function automatic octet_q_t good_frame(input logic [DATA_W-1:0] prio,
                                            input logic [TOPIC_W-1:0] topic_decl,
                                            input int topic_bytes, input int payload_bytes);
        octet_q_t    f;
        logic [31:0] len;
        len = 32'(3 + topic_bytes + payload_bytes);
        f.push_back(len[31:24]);
        f.push_back(len[23:16]);
        f.push_back(len[15:8]);
        f.push_back(len[7:0]);
        f.push_back(prio);
        f.push_back(topic_decl[15:8]);
        f.push_back(topic_decl[7:0]);
        repeat (topic_bytes + payload_bytes) f.push_back(DATA_W'($urandom_range(255)));
        return f;
    endfunction

    // Mostly well-formed frames with random content, the rest damaged or noise
    function automatic octet_q_t random_frame();
        octet_q_t           f;
        int                 pick;
        int                 n;
        int                 tb;
        int                 pb;
        logic [DATA_W-1:0]  pr;
        logic [TOPIC_W-1:0] td;
        pick = $urandom_range(99);
        tb   = $urandom_range(1, 6);
        pb   = $urandom_range(0, 8);
        // keep the priority near the limit now and then
        case ($urandom_range(9))
            0:       pr = prio_limit;
            1:       pr = prio_limit + 8'd1;
            2:       pr = DATA_W'($urandom_range(255));
            default: pr = DATA_W'($urandom_range(prio_limit));
        endcase
        td = TOPIC_W'(tb);
        if (pick < 5)
            td = '0;
        else if (pick < 10)
            td = TOPIC_W'($urandom_range(65535));
        f = good_frame(pr, td, tb, pb);

        if (pick >= 65 && pick < 80) begin
            // damage it: cut short, overlong, or a bad length prefix
            case ($urandom_range(2))
                0: begin
                    n = $urandom_range(1, f.size() - 1);
                    while (f.size() > n)
                        void'(f.pop_back());
                end
                1:       repeat ($urandom_range(1, 3)) f.push_back(DATA_W'($urandom_range(255)));
                default: f[$urandom_range(3)] = DATA_W'($urandom_range(255));
            endcase
        end else if (pick >= 80) begin
            f.delete();
            n = (pick < 90) ? $urandom_range(1, 7) : $urandom_range(1, 20);
            repeat (n) f.push_back(DATA_W'($urandom_range(255)));
        end
        return f;
    endfunction

    task automatic send_random_words(input int count);
        int start;
        start = words_sent;
        while (words_sent - start < count)
            send_frame(random_frame());
    endtask

    // One frame for every status, short frames with missing header fields, every word class
    task automatic test_directed_statuses();
        send_frame('{8'hFF});
        send_frame('{8'h00, 8'h00, 8'h00, 8'h00, 8'hAB});
        send_frame('{8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h80});
        send_frame('{8'h00, 8'h00, 8'h00, 8'h03, 8'hFF, 8'h00, 8'h01});
        send_frame('{8'h00, 8'h00, 8'h00, 8'h03, 8'h03, 8'hFF, 8'hFF});
        send_frame('{8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00});
        send_frame('{8'h00, 8'h00, 8'h00, 8'h05, 8'h02, 8'h00, 8'h01, 8'h5A, 8'hFF});
        wait_idle();
    endtask

    // Stall the result side for a long stretch while words keep coming
    task automatic test_output_backpressure();
        steady    = 1'b1;
        hold_left = HOLD_CYCLES;
        send_random_words(80);
        wait_idle();
        steady = 1'b0;
    endtask

    // Random traffic, first with no idling at all, then with random gaps on both sides
    task automatic test_random_traffic();
        steady = 1'b1;
        send_random_words(150);
        wait_idle();
        steady = 1'b0;
        send_random_words(250);
        wait_idle();
    endtask

    // Sweep max_priority through its extremes and a random middle value, then back to the reset value
    task automatic test_priority_limits();
        logic [DATA_W-1:0] limits [4];
        limits[0] = 8'd0;
        limits[1] = 8'd255;
        limits[2] = odd_limit;
        limits[3] = MAX_PRIORITY_RESET;
        foreach (limits[i]) begin
            write_max_priority(limits[i]);
            send_random_words(280);
            wait_idle();
        end
    endtask

    // Hold reset, run the tests in turn, then give the verdict
    initial begin
        odd_limit = DATA_W'($urandom_range(1, 254));
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_statuses();
        test_output_backpressure();
        test_random_traffic();
        test_priority_limits();
        wait_idle();

        $display("covered %0d frames, %0d words sent, %0d checked; max_priority 3, 0, 255, %0d",
                 frames_sent, words_sent, words_checked, odd_limit);
        $display("statuses: ok %0d, short prefix %0d, mismatch %0d, short body %0d, %s %0d, %s %0d,",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 "bad priority", status_hits[4], "overrun", status_hits[5]);
        $display("          empty topic %0d", status_hits[6]);
        if (errors == 0 && parsed_words.size() == 0) begin
            $display("length_prefixed_topic_frame_parser_test: PASS");
        end else begin
            $display("length_prefixed_topic_frame_parser_test: FAIL");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d words still pending", parsed_words.size());
        $display("length_prefixed_topic_frame_parser_test: FAIL");
        $finish;
    end

endmodule
